>>> src/sgm_pkg.sv
package sgm_pkg;

	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned CHAN_W   = 3;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned PROD_W   = 2 * GAIN_W;
	localparam int unsigned ROOT_STEPS = PROD_W / 2;
	localparam int unsigned STEP_W   = $clog2(ROOT_STEPS);

	localparam logic [GAIN_W-1:0]  Q15_ONE     = 16'h8000;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;
	localparam logic [COUNT_W-1:0] COUNT_MONO  = 4'd1;

	typedef enum logic [2:0] {
		REG_MASTER_GAIN   = 3'd0,
		REG_LEFT_TRIM     = 3'd1,
		REG_RIGHT_TRIM    = 3'd2,
		REG_MUTE_LEFT     = 3'd3,
		REG_MUTE_RIGHT    = 3'd4,
		REG_CHANNEL_COUNT = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		GS_IDLE,
		GS_PROD,
		GS_ROOT
	} gain_state_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  master_gain;
		logic [GAIN_W-1:0]  left_trim;
		logic [GAIN_W-1:0]  right_trim;
		logic               mute_left;
		logic               mute_right;
		logic [COUNT_W-1:0] channel_count;
	} sgm_cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [CHAN_W-1:0]          channel_index;
		logic                       block_end;
	} sgm_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       block_end_out;
	} sgm_out_t;

	function automatic logic [GAIN_W-1:0] sat_q15(input logic [GAIN_W-1:0] g);
		return (g > Q15_ONE) ? Q15_ONE : g;
	endfunction

endpackage

>>> src/sgm_regs.sv
module sgm_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sgm_pkg::ADDR_W-1:0]     paddr,
	input  logic [sgm_pkg::DATA_W-1:0]     pwdata,
	output logic [sgm_pkg::DATA_W-1:0]     prdata,
	output sgm_pkg::sgm_cfg_t              cfg,
	output logic                           kick
);

	sgm_pkg::sgm_cfg_t cfg_q;
	sgm_pkg::reg_idx_t idx;
	logic              wr_en;
	logic              idx_ok;

	assign idx   = sgm_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite;

	always_comb begin
		case (idx)
			sgm_pkg::REG_MASTER_GAIN,
			sgm_pkg::REG_LEFT_TRIM,
			sgm_pkg::REG_RIGHT_TRIM,
			sgm_pkg::REG_MUTE_LEFT,
			sgm_pkg::REG_MUTE_RIGHT,
			sgm_pkg::REG_CHANNEL_COUNT: idx_ok = 1'b1;
			default:                    idx_ok = 1'b0;
		endcase
	end

	// a write to a real register restarts the multiplier update
	assign kick = wr_en && idx_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_gain   <= sgm_pkg::Q15_ONE;
			cfg_q.left_trim     <= sgm_pkg::Q15_ONE;
			cfg_q.right_trim    <= sgm_pkg::Q15_ONE;
			cfg_q.mute_left     <= 1'b0;
			cfg_q.mute_right    <= 1'b0;
			cfg_q.channel_count <= sgm_pkg::COUNT_RESET;
		end else if (wr_en) begin
			case (idx)
				sgm_pkg::REG_MASTER_GAIN:   cfg_q.master_gain   <= pwdata[15:0];
				sgm_pkg::REG_LEFT_TRIM:     cfg_q.left_trim     <= pwdata[15:0];
				sgm_pkg::REG_RIGHT_TRIM:    cfg_q.right_trim    <= pwdata[15:0];
				sgm_pkg::REG_MUTE_LEFT:     cfg_q.mute_left     <= pwdata[0];
				sgm_pkg::REG_MUTE_RIGHT:    cfg_q.mute_right    <= pwdata[0];
				sgm_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sgm_pkg::REG_MASTER_GAIN:   prdata = {16'd0, cfg_q.master_gain};
			sgm_pkg::REG_LEFT_TRIM:     prdata = {16'd0, cfg_q.left_trim};
			sgm_pkg::REG_RIGHT_TRIM:    prdata = {16'd0, cfg_q.right_trim};
			sgm_pkg::REG_MUTE_LEFT:     prdata = {31'd0, cfg_q.mute_left};
			sgm_pkg::REG_MUTE_RIGHT:    prdata = {31'd0, cfg_q.mute_right};
			sgm_pkg::REG_CHANNEL_COUNT: prdata = {28'd0, cfg_q.channel_count};
			default:                    prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> src/sgm_isqrt.sv
module sgm_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic [sgm_pkg::PROD_W-1:0]    operand,
	output logic [sgm_pkg::GAIN_W-1:0]    root,
	output logic                          done
);

	localparam int unsigned REM_W = sgm_pkg::GAIN_W + 1;

	logic [sgm_pkg::PROD_W-1:0] value_q;
	logic [REM_W-1:0]           rem_q;
	logic [sgm_pkg::GAIN_W-1:0] root_q;
	logic [sgm_pkg::STEP_W-1:0] step_q;
	logic                       run_q;
	logic                       done_q;
	logic [REM_W+1:0]           work;
	logic [REM_W+1:0]           trial;
	logic                       fits;

	// one root bit per cycle: bring down two operand bits, try 4*root+1
	assign work  = {rem_q, value_q[sgm_pkg::PROD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits  = (work >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (load) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= sgm_pkg::STEP_W'(sgm_pkg::ROOT_STEPS - 1);
		end else if (run_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= operand;
			rem_q   <= '0;
			root_q  <= '0;
		end else if (run_q) begin
			value_q <= {value_q[sgm_pkg::PROD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= REM_W'(work - trial);
				root_q <= {root_q[sgm_pkg::GAIN_W-2:0], 1'b1};
			end else begin
				rem_q  <= work[REM_W-1:0];
				root_q <= {root_q[sgm_pkg::GAIN_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

>>> src/sgm_gain.sv
module sgm_gain (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sgm_pkg::sgm_cfg_t           cfg,
	input  logic                        kick,
	output logic [sgm_pkg::GAIN_W-1:0]  left_mul,
	output logic [sgm_pkg::GAIN_W-1:0]  right_mul,
	output logic                        busy
);

	sgm_pkg::gain_state_t       state_q;
	sgm_pkg::gain_state_t       state_d;
	logic                       load;
	logic                       commit;
	logic [sgm_pkg::PROD_W-1:0] left_prod;
	logic [sgm_pkg::PROD_W-1:0] right_prod;
	logic [sgm_pkg::GAIN_W-1:0] left_root;
	logic [sgm_pkg::GAIN_W-1:0] right_root;
	logic                       left_done;
	logic                       right_done;
	logic                       root_done;
	logic [sgm_pkg::GAIN_W-1:0] left_mul_q;
	logic [sgm_pkg::GAIN_W-1:0] right_mul_q;

	assign left_prod  = sgm_pkg::sat_q15(cfg.master_gain) * sgm_pkg::sat_q15(cfg.left_trim);
	assign right_prod = sgm_pkg::sat_q15(cfg.master_gain) * sgm_pkg::sat_q15(cfg.right_trim);

	// both roots run in lockstep
	assign root_done = left_done && right_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgm_pkg::GS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		commit  = 1'b0;
		case (state_q)
			sgm_pkg::GS_IDLE: begin
				if (kick) state_d = sgm_pkg::GS_PROD;
			end
			sgm_pkg::GS_PROD: begin
				load = 1'b1;
				state_d = kick ? sgm_pkg::GS_PROD : sgm_pkg::GS_ROOT;
			end
			sgm_pkg::GS_ROOT: begin
				if (kick) begin
					state_d = sgm_pkg::GS_PROD;
				end else if (root_done) begin
					commit  = 1'b1;
					state_d = sgm_pkg::GS_IDLE;
				end
			end
			default: state_d = sgm_pkg::GS_IDLE;
		endcase
	end

	sgm_isqrt u_root_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.operand (left_prod),
		.root    (left_root),
		.done    (left_done)
	);

	sgm_isqrt u_root_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.operand (right_prod),
		.root    (right_root),
		.done    (right_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_mul_q  <= sgm_pkg::Q15_ONE;
			right_mul_q <= sgm_pkg::Q15_ONE;
		end else if (commit) begin
			left_mul_q  <= cfg.mute_left  ? '0 : left_root;
			right_mul_q <= cfg.mute_right ? '0 : right_root;
		end
	end

	assign left_mul  = left_mul_q;
	assign right_mul = right_mul_q;
	assign busy      = (state_q != sgm_pkg::GS_IDLE);

endmodule

>>> src/sgm_datapath.sv
module sgm_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  sgm_pkg::sgm_in_t            data,
	input  logic [sgm_pkg::GAIN_W-1:0]  left_mul,
	input  logic [sgm_pkg::GAIN_W-1:0]  right_mul,
	input  logic                        mono,
	output logic                        strobe,
	output sgm_pkg::sgm_out_t           result
);

	localparam int unsigned P_W = sgm_pkg::SAMPLE_W + sgm_pkg::GAIN_W + 1;

	sgm_pkg::sgm_in_t           data_s1;
	logic                       valid_s1;
	sgm_pkg::sgm_out_t          result_s2;
	logic                       valid_s2;
	logic [sgm_pkg::GAIN_W-1:0] mul;
	logic signed [P_W-1:0]      prod;
	logic signed [P_W-1:0]      biased;
	logic signed [P_W-1:0]      quot;
	logic signed [sgm_pkg::SAMPLE_W-1:0] clamped;

	always_comb begin
		if (mono) begin
			mul = (left_mul > right_mul) ? left_mul : right_mul;
		end else if (data_s1.channel_index == '0) begin
			mul = left_mul;
		end else begin
			mul = right_mul;
		end
	end

	assign prod = data_s1.sample_in * $signed({1'b0, mul});
	// bias negatives so the shift truncates toward zero
	assign biased = prod + (prod[P_W-1] ? P_W'(32767) : P_W'(0));
	assign quot   = biased >>> 15;

	always_comb begin
		if (quot > P_W'(32767)) begin
			clamped = 16'sh7fff;
		end else if (quot < -P_W'(32768)) begin
			clamped = 16'sh8000;
		end else begin
			clamped = quot[sgm_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data;
		end
		if (valid_s1) begin
			result_s2.sample_out    <= clamped;
			result_s2.block_end_out <= data_s1.block_end;
		end
	end

	assign strobe = valid_s2;
	assign result = result_s2;

endmodule

>>> src/stereo_gain_mute_stage.sv
// stereo gain and mute stage. one item is accepted per cycle while busy is low; the item
// is registered in data_s1 and its scaled sample in result_s2, which drives result with
// strobe high for exactly one cycle. the receiver cannot stall, so it must take every
// strobed result. a register write (master gain, trims, mutes, channel count) restarts
// the square root update of both channel multipliers, which runs one root bit per cycle
// in one iterative unit per channel: busy goes high at the edge that writes the register
// and stays high until both roots are committed, no item is taken meanwhile; back to back
// writes restart the update. write registers only while no items are in flight.
module stereo_gain_mute_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sgm_pkg::ADDR_W-1:0]  paddr,
	input  logic [sgm_pkg::DATA_W-1:0]  pwdata,
	output logic [sgm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  sgm_pkg::sgm_in_t            data,
	output logic                        strobe,
	output sgm_pkg::sgm_out_t           result
);

	sgm_pkg::sgm_cfg_t          cfg;
	logic                       kick;
	logic [sgm_pkg::GAIN_W-1:0] left_mul;
	logic [sgm_pkg::GAIN_W-1:0] right_mul;
	logic                       mono;

	assign pready = 1'b1;
	assign mono   = (cfg.channel_count == sgm_pkg::COUNT_MONO);

	sgm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg),
		.kick    (kick)
	);

	sgm_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.kick      (kick),
		.left_mul  (left_mul),
		.right_mul (right_mul),
		.busy      (busy)
	);

	sgm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (start && !busy),
		.data      (data),
		.left_mul  (left_mul),
		.right_mul (right_mul),
		.mono      (mono),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

>>> src/sgm_checker.sv
module sgm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [sgm_pkg::ADDR_W-1:0]  paddr,
	input logic                        start,
	input logic                        busy,
	input sgm_pkg::sgm_in_t            data,
	input logic                        strobe,
	input sgm_pkg::sgm_out_t           result
);

	// every accepted item comes out as a strobed result
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 strobe)
		else $error("accepted item produced no result");

	// no result without an accepted item before it
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(start && !busy, 2))
		else $error("result without accepted item");

	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.block_end_out == $past(data.block_end, 2)))
		else $error("block end flag lost");

	// a write to a real register starts the multiplier update
	assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && (paddr[4:2] <= sgm_pkg::REG_CHANNEL_COUNT)) |=> busy)
		else $error("register write did not raise busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(psel && penable && pwrite))
		else $error("busy rose without a register write");

endmodule

bind stereo_gain_mute_stage sgm_checker u_sgm_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.paddr   (paddr),
	.start   (start),
	.busy    (busy),
	.data    (data),
	.strobe  (strobe),
	.result  (result)
);

>>> bench/stereo_gain_mute_stage_test.sv
module stereo_gain_mute_stage_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_UNUSED_6 = 3'd6;
	localparam logic [2:0] REG_UNUSED_7 = 3'd7;
	localparam int PHASES     = 14;
	localparam int PHASE_LEN  = 120;
	localparam int MAX_GAP    = 17;
	localparam int PRINT_MAX  = 50;

	typedef enum logic {
		ROW_ITEM,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [2:0]         reg_sel;
		logic [31:0]        wval;
		sgm_pkg::sgm_in_t   item;
		logic               typed;
		sgm_pkg::sgm_out_t  want;
	} plan_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [sgm_pkg::ADDR_W-1:0]   paddr;
	logic [sgm_pkg::DATA_W-1:0]   pwdata;
	logic [sgm_pkg::DATA_W-1:0]   prdata;
	logic                         pready;
	logic                         start;
	logic                         busy;
	sgm_pkg::sgm_in_t             data;
	logic                         strobe;
	sgm_pkg::sgm_out_t            result;

	// shadow of the gain registers and the two channel multipliers
	logic [sgm_pkg::GAIN_W-1:0]   master_q;
	logic [sgm_pkg::GAIN_W-1:0]   left_trim_q;
	logic [sgm_pkg::GAIN_W-1:0]   right_trim_q;
	logic                         mute_left_q;
	logic                         mute_right_q;
	logic [sgm_pkg::COUNT_W-1:0]  chan_count_q;
	logic [sgm_pkg::GAIN_W-1:0]   left_mul;
	logic [sgm_pkg::GAIN_W-1:0]   right_mul;

	sgm_pkg::sgm_out_t            pending_samples[$];
	plan_row_t                    plan[$];
	int                           mismatches;

	stereo_gain_mute_stage dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.data    (data),
		.strobe  (strobe),
		.result  (result)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [sgm_pkg::GAIN_W-1:0] clip_unity(logic [sgm_pkg::GAIN_W-1:0] g);
		return (g > sgm_pkg::Q15_ONE) ? sgm_pkg::Q15_ONE : g;
	endfunction

	function automatic logic [sgm_pkg::GAIN_W-1:0] floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned cand;
		r = 0;
		for (int b = 15; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if (cand * cand <= v)
				r = cand;
		end
		return r[sgm_pkg::GAIN_W-1:0];
	endfunction

	function automatic void refresh_multipliers();
		longint unsigned m;
		m = longint'(clip_unity(master_q));
		left_mul  = mute_left_q  ? '0 : floor_root(m * longint'(clip_unity(left_trim_q)));
		right_mul = mute_right_q ? '0 : floor_root(m * longint'(clip_unity(right_trim_q)));
	endfunction

	function automatic void shadow_write(logic [2:0] idx, logic [31:0] val);
		case (idx)
			sgm_pkg::REG_MASTER_GAIN:   master_q     = val[sgm_pkg::GAIN_W-1:0];
			sgm_pkg::REG_LEFT_TRIM:     left_trim_q  = val[sgm_pkg::GAIN_W-1:0];
			sgm_pkg::REG_RIGHT_TRIM:    right_trim_q = val[sgm_pkg::GAIN_W-1:0];
			sgm_pkg::REG_MUTE_LEFT:     mute_left_q  = val[0];
			sgm_pkg::REG_MUTE_RIGHT:    mute_right_q = val[0];
			sgm_pkg::REG_CHANNEL_COUNT: chan_count_q = val[sgm_pkg::COUNT_W-1:0];
			default:                    return;
		endcase
		refresh_multipliers();
	endfunction

	function automatic sgm_pkg::sgm_out_t scaled_sample(sgm_pkg::sgm_in_t it);
		sgm_pkg::sgm_out_t o;
		int s;
		int m;
		int r;
		s = $signed(it.sample_in);
		if (chan_count_q == sgm_pkg::COUNT_MONO)
			m = (left_mul > right_mul) ? int'(left_mul) : int'(right_mul);
		else if (it.channel_index == 0)
			m = int'(left_mul);
		else
			m = int'(right_mul);
		r = (s * m) / 32768;
		if (r < -32768)
			r = -32768;
		if (r > 32767)
			r = 32767;
		o.sample_out = r[sgm_pkg::SAMPLE_W-1:0];
		o.block_end_out = it.block_end;
		return o;
	endfunction

	function automatic plan_row_t item_row(int s, int ch, bit be, bit typed, int want);
		plan_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.item.sample_in = s[sgm_pkg::SAMPLE_W-1:0];
		row.item.channel_index = ch[sgm_pkg::CHAN_W-1:0];
		row.item.block_end = be;
		row.typed = typed;
		row.want.sample_out = want[sgm_pkg::SAMPLE_W-1:0];
		row.want.block_end_out = be;
		return row;
	endfunction

	function automatic plan_row_t write_row(logic [2:0] idx, logic [31:0] val);
		plan_row_t row;
		row = '0;
		row.kind = ROW_WRITE;
		row.reg_sel = idx;
		row.wval = val;
		return row;
	endfunction

	function automatic logic [31:0] gain_value();
		logic [15:0] lo;
		logic [15:0] hi;
		case ($urandom_range(0, 7))
			0:       lo = 16'h0000;
			1:       lo = sgm_pkg::Q15_ONE;
			2:       lo = 16'hffff;
			3:       lo = 16'h7fff;
			4, 5:    lo = 16'($urandom_range(0, 32768));
			6:       lo = 16'($urandom_range(0, 65535));
			default: lo = 16'($urandom_range(1, 64));
		endcase
		hi = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'h0000;
		return {hi, lo};
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_MAX)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		shadow_write(idx, val);
		@(posedge clk);
	endtask

	// start is left high after acceptance so a zero gap needs no second assignment
	task automatic send_item(sgm_pkg::sgm_in_t it, int gap, bit typed,
			sgm_pkg::sgm_out_t want);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		data  <= it;
		do @(posedge clk); while (busy);
		pending_samples.push_back(typed ? want : scaled_sample(it));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	always @(posedge clk) begin
		sgm_pkg::sgm_out_t want;
		if (arst_n && strobe) begin
			if (pending_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected item sample_out=%0d",
					$signed(result.sample_out)));
			end else begin
				want = pending_samples.pop_front();
				if (result.sample_out !== want.sample_out)
					report_mismatch($sformatf("sample_out %0d, wanted %0d",
						$signed(result.sample_out), $signed(want.sample_out)));
				if (result.block_end_out !== want.block_end_out)
					report_mismatch($sformatf("block_end_out %b, wanted %b",
						result.block_end_out, want.block_end_out));
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		sgm_pkg::sgm_in_t   it;
		sgm_pkg::sgm_out_t  none;
		plan_row_t          row;
		bit                 burst;
		logic [2:0]         idx;

		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		start   <= 1'b0;
		data    <= '0;
		none = '0;
		mismatches = 0;
		master_q     = sgm_pkg::Q15_ONE;
		left_trim_q  = sgm_pkg::Q15_ONE;
		right_trim_q = sgm_pkg::Q15_ONE;
		mute_left_q  = 1'b0;
		mute_right_q = 1'b0;
		chan_count_q = sgm_pkg::COUNT_RESET;
		left_mul     = sgm_pkg::Q15_ONE;
		right_mul    = sgm_pkg::Q15_ONE;

		// unity gain after reset
		plan.push_back(item_row(32767, 0, 0, 1, 32767));
		plan.push_back(item_row(-32768, 1, 1, 1, -32768));
		plan.push_back(item_row(0, 7, 0, 1, 0));
		plan.push_back(item_row(-1, 0, 1, 1, -1));
		plan.push_back(item_row(1, 5, 0, 1, 1));
		// master above unity is clipped to unity
		plan.push_back(write_row(sgm_pkg::REG_MASTER_GAIN, 32'h0000_ffff));
		plan.push_back(item_row(-32768, 0, 0, 1, -32768));
		plan.push_back(write_row(sgm_pkg::REG_MUTE_LEFT, 32'd1));
		plan.push_back(item_row(32767, 0, 1, 1, 0));
		plan.push_back(item_row(-32768, 2, 0, 1, -32768));
		// mono takes the larger multiplier
		plan.push_back(write_row(sgm_pkg::REG_CHANNEL_COUNT, 32'd1));
		plan.push_back(item_row(12345, 0, 0, 1, 12345));
		plan.push_back(write_row(sgm_pkg::REG_MUTE_RIGHT, 32'd1));
		plan.push_back(item_row(-32768, 3, 1, 1, 0));
		plan.push_back(write_row(sgm_pkg::REG_MUTE_LEFT, 32'd0));
		plan.push_back(write_row(sgm_pkg::REG_MUTE_RIGHT, 32'd0));
		plan.push_back(write_row(sgm_pkg::REG_MASTER_GAIN, 32'd16384));
		plan.push_back(item_row(32767, 0, 0, 0, 0));
		plan.push_back(write_row(sgm_pkg::REG_LEFT_TRIM, 32'd0));
		plan.push_back(write_row(sgm_pkg::REG_RIGHT_TRIM, 32'h0000_8001));
		plan.push_back(item_row(-32768, 0, 1, 0, 0));
		// count zero and above eight behave like stereo
		plan.push_back(write_row(sgm_pkg::REG_CHANNEL_COUNT, 32'd0));
		plan.push_back(item_row(1000, 0, 0, 1, 0));
		plan.push_back(item_row(-32768, 1, 0, 0, 0));
		plan.push_back(write_row(sgm_pkg::REG_CHANNEL_COUNT, 32'd15));
		plan.push_back(item_row(32767, 6, 1, 0, 0));
		plan.push_back(item_row(-5, 0, 0, 1, 0));
		// channel index past the frame still uses the right multiplier
		plan.push_back(write_row(sgm_pkg::REG_CHANNEL_COUNT, 32'd3));
		plan.push_back(item_row(32767, 7, 0, 0, 0));
		// unused register slots are ignored
		plan.push_back(write_row(REG_UNUSED_6, 32'd1));
		plan.push_back(write_row(REG_UNUSED_7, 32'hffff_ffff));
		plan.push_back(item_row(-32768, 4, 1, 0, 0));
		plan.push_back(write_row(sgm_pkg::REG_MASTER_GAIN, 32'd1));
		plan.push_back(write_row(sgm_pkg::REG_LEFT_TRIM, 32'd1));
		plan.push_back(item_row(32767, 0, 0, 0, 0));
		plan.push_back(item_row(-32768, 0, 1, 0, 0));
		plan.push_back(write_row(sgm_pkg::REG_MASTER_GAIN, 32'd0));
		plan.push_back(item_row(32767, 1, 0, 1, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.kind == ROW_WRITE) begin
				drain();
				cfg_write(row.reg_sel, row.wval);
			end else begin
				send_item(row.item, $urandom_range(0, MAX_GAP), row.typed, row.want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p == 0) begin
				// back to reset values, all of unity gain
				cfg_write(sgm_pkg::REG_MASTER_GAIN, {16'h0, sgm_pkg::Q15_ONE});
				cfg_write(sgm_pkg::REG_LEFT_TRIM, {16'h0, sgm_pkg::Q15_ONE});
				cfg_write(sgm_pkg::REG_RIGHT_TRIM, {16'h0, sgm_pkg::Q15_ONE});
				cfg_write(sgm_pkg::REG_MUTE_LEFT, 32'd0);
				cfg_write(sgm_pkg::REG_MUTE_RIGHT, 32'd0);
				cfg_write(sgm_pkg::REG_CHANNEL_COUNT, {28'h0, sgm_pkg::COUNT_RESET});
			end else if (p == 1) begin
				cfg_write(sgm_pkg::REG_MASTER_GAIN, 32'hffff_ffff);
				cfg_write(sgm_pkg::REG_LEFT_TRIM, 32'h0000_ffff);
				cfg_write(sgm_pkg::REG_RIGHT_TRIM, 32'h0000_0000);
				cfg_write(sgm_pkg::REG_CHANNEL_COUNT, {28'h0, sgm_pkg::COUNT_MONO});
			end else begin
				for (int r = 0; r <= sgm_pkg::REG_CHANNEL_COUNT; r++) begin
					if ($urandom_range(0, 1)) begin
						idx = r[2:0];
						if (idx == sgm_pkg::REG_MUTE_LEFT || idx == sgm_pkg::REG_MUTE_RIGHT)
							cfg_write(idx, $urandom_range(0, 3) == 0 ? $urandom : 32'd0);
						else if (idx == sgm_pkg::REG_CHANNEL_COUNT)
							cfg_write(idx, $urandom_range(0, 1)
								? 32'($urandom_range(1, 8)) : $urandom);
						else
							cfg_write(idx, gain_value());
					end
				end
				if ($urandom_range(0, 3) == 0)
					cfg_write($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, $urandom);
			end
			burst = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_LEN; n++) begin
				case ($urandom_range(0, 9))
					0:       it.sample_in = 16'h8000;
					1:       it.sample_in = 16'h7fff;
					2:       it.sample_in = 16'h0000;
					3:       it.sample_in = 16'hffff;
					default: it.sample_in = 16'($urandom_range(0, 65535));
				endcase
				it.channel_index = 3'($urandom_range(0, 7));
				it.block_end = ($urandom_range(0, 7) == 0);
				send_item(it, burst ? 0 : $urandom_range(0, MAX_GAP), 1'b0, none);
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> stereo_gain_mute_stage.f
src/sgm_pkg.sv
src/sgm_regs.sv
src/sgm_isqrt.sv
src/sgm_gain.sv
src/sgm_datapath.sv
src/stereo_gain_mute_stage.sv
src/sgm_checker.sv
bench/stereo_gain_mute_stage_test.sv
